// ===== rtl/core/button_debounce_long_press_defines.svh =====
// ---------------------------------------------------------------------------
// button_debounce_long_press_defines.svh
// Assertion macros shared by the button debounce RTL.
// ---------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_DEFINES_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset
`define BDLP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset
`define BDLP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/bdlp_pkg.sv =====
// ---------------------------------------------------------------------------
// bdlp_pkg
// Types, register codes and reset values for the button debounce block.
// ---------------------------------------------------------------------------
`default_nettype none

package bdlp_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned IN_TDW   = 40;
    localparam int unsigned OUT_TDW  = 8;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST_MS   = 16'd20;
    localparam logic [CFG_W-1:0] LONG_PRESS_RST_MS = 16'd3000;

    // Configuration register indexes
    typedef enum logic {
        REG_DEBOUNCE   = 1'b0,
        REG_LONG_PRESS = 1'b1
    } t_cfg_idx;

    // One poll beat as held in the input register
    typedef struct packed {
        logic              reset_raw;
        logic              next_raw;
        logic [TIME_W-1:0] now_ms;
    } t_in_beat;

    // One result beat as held in the output register
    typedef struct packed {
        logic reset_level;
        logic next_level;
        logic long_press_event;
        logic next_press_event;
    } t_out_beat;

    // Wrapping elapsed time compared against a 16-bit limit
    function automatic logic elapsed_ge(
        input logic [TIME_W-1:0] now,
        input logic [TIME_W-1:0] mark,
        input logic [CFG_W-1:0]  limit
    );
        logic [TIME_W-1:0] diff;
        diff = now - mark;
        return (diff[TIME_W-1:CFG_W] != '0) || (diff[CFG_W-1:0] >= limit);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/button_debounce_long_press.sv =====
// An accepted input beat passes the input register, then the output register, to m_axis.
// Throughput: one poll per cycle unless m_axis stalls; the only loop is the per-poll
// button state update, computed between the input and output registers.
// Reset (i_rst_n low, synchronous): both buttons released, timers at 0,
// debounce 20 ms, long press 3000 ms, both pipeline stages empty.
// ---------------------------------------------------------------------------
// button_debounce_long_press
// Two-button debouncer with press-edge event and one-shot long-press event.
// ---------------------------------------------------------------------------
`default_nettype none

`include "button_debounce_long_press_defines.svh"

module button_debounce_long_press
    import bdlp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // config write port
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_addr,
    input  wire logic [CFG_W-1:0]   i_cfg_wdata,
    // poll stream
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [IN_TDW-1:0]  s_axis_tdata,  // now_ms[31:0], next_raw, reset_raw, pad
    // result stream
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [OUT_TDW-1:0]      m_axis_tdata   // next_press_event, long_press_event,
                                                   // next_level, reset_level, pad
);

    // Configuration
    logic [CFG_W-1:0]  r_debounce_ms;
    logic [CFG_W-1:0]  r_long_press_ms;

    // Button state
    logic              r_first_stable, n_first_stable;
    logic              r_first_last_raw;
    logic [TIME_W-1:0] r_first_change_time;
    logic              r_second_stable, n_second_stable;
    logic              r_second_last_raw;
    logic [TIME_W-1:0] r_second_change_time;
    logic [TIME_W-1:0] r_press_start_time;
    logic              r_long_done, n_long_done;

    // Pipeline
    logic              r_in_valid;
    t_in_beat          r_in;
    logic              r_out_valid;
    t_out_beat         r_out;
    t_out_beat         n_out;
    logic              w_adv;

    logic              w_first_chg, w_second_chg;
    logic              w_first_ok, w_second_ok;
    logic              w_first_edge, w_second_edge;
    logic              w_long_ok, w_long_fire;

    // Handshake
    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || !r_out_valid || m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDW-4){1'b0}}, r_out};

    // Debounce: a raw change restarts the timer, so elapsed is zero then
    always_comb begin
        w_first_chg  = r_in.next_raw != r_first_last_raw;
        w_second_chg = r_in.reset_raw != r_second_last_raw;
        w_first_ok   = w_first_chg ? (r_debounce_ms == '0)
                     : elapsed_ge(r_in.now_ms, r_first_change_time, r_debounce_ms);
        w_second_ok  = w_second_chg ? (r_debounce_ms == '0)
                     : elapsed_ge(r_in.now_ms, r_second_change_time, r_debounce_ms);

        n_first_stable  = (w_first_ok && r_in.next_raw != r_first_stable)
                        ? r_in.next_raw : r_first_stable;
        n_second_stable = (w_second_ok && r_in.reset_raw != r_second_stable)
                        ? r_in.reset_raw : r_second_stable;
        w_first_edge    = r_first_stable && !n_first_stable;
        w_second_edge   = r_second_stable && !n_second_stable;

        // Hold timer restarts on the stable press edge
        w_long_ok   = w_second_edge ? (r_long_press_ms == '0)
                    : elapsed_ge(r_in.now_ms, r_press_start_time, r_long_press_ms);
        w_long_fire = !n_second_stable && (w_second_edge || !r_long_done) && w_long_ok;
        n_long_done = w_long_fire || (r_long_done && !w_second_edge);

        n_out.next_press_event = w_first_edge;
        n_out.long_press_event = w_long_fire;
        n_out.next_level       = n_first_stable;
        n_out.reset_level      = n_second_stable;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms   <= DEBOUNCE_RST_MS;
            r_long_press_ms <= LONG_PRESS_RST_MS;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                REG_DEBOUNCE:   r_debounce_ms   <= i_cfg_wdata;
                REG_LONG_PRESS: r_long_press_ms <= i_cfg_wdata;
                default:        r_debounce_ms   <= r_debounce_ms;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in.now_ms    <= s_axis_tdata[TIME_W-1:0];
            r_in.next_raw  <= s_axis_tdata[TIME_W];
            r_in.reset_raw <= s_axis_tdata[TIME_W+1];
        end
    end

    // Button state update, one beat per advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_stable       <= 1'b1;
            r_first_last_raw     <= 1'b1;
            r_first_change_time  <= '0;
            r_second_stable      <= 1'b1;
            r_second_last_raw    <= 1'b1;
            r_second_change_time <= '0;
            r_press_start_time   <= '0;
            r_long_done          <= 1'b0;
        end else if (w_adv) begin
            r_first_stable    <= n_first_stable;
            r_first_last_raw  <= r_in.next_raw;
            r_second_stable   <= n_second_stable;
            r_second_last_raw <= r_in.reset_raw;
            r_long_done       <= n_long_done;
            if (w_first_chg) begin
                r_first_change_time <= r_in.now_ms;
            end
            if (w_second_chg) begin
                r_second_change_time <= r_in.now_ms;
            end
            if (w_second_edge) begin
                r_press_start_time <= r_in.now_ms;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || m_axis_tready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    // Checks
    `BDLP_ASSERT_NOW(a_press_ev_level, r_out_valid && r_out.next_press_event,
        !r_out.next_level, "press event with first button released")
    `BDLP_ASSERT_NOW(a_long_ev_level, r_out_valid && r_out.long_press_event,
        !r_out.reset_level, "long-press event with second button released")
    `BDLP_ASSERT_NOW(a_long_ev_done, r_out_valid && r_out.long_press_event,
        r_long_done, "long-press event left the one-shot unarmed state clear")
    `BDLP_ASSERT_NEXT(a_stall_hold, r_in_valid && r_out_valid && !m_axis_tready,
        r_in_valid, "input beat lost while output stalled")

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for button_debounce_long_press. Poll beats carrying a
// millisecond time and two raw button levels are streamed in with random
// gaps and back-pressure. An in-bench predictor of both debouncers and of
// the long-press timer checks every result beat field by field. A directed
// pass covers the timing edges, then random button activity with bounces
// runs under several register settings, the extremes among them.
// ---------------------------------------------------------------------------
module testbench;
    import bdlp_pkg::*;

    localparam int BTN_NEXT          = 0;
    localparam int BTN_RESET         = 1;
    localparam int N_SETS            = 9;
    localparam int POLLS_PER_SET     = 115;
    localparam int LONG_STALL_CYCLES = 300;
    localparam int MAX_REPORTS       = 10;
    localparam int TIMEOUT_UNITS     = 2_000_000;

    // Random-phase register settings, set 0 in the lowest 16 bits
    localparam logic [N_SETS*CFG_W-1:0] SET_DEBOUNCE = {
        16'd0, 16'd2, 16'd7, 16'd65535, 16'd0, 16'd65535, 16'd20, 16'd3, 16'd1
    };
    localparam logic [N_SETS*CFG_W-1:0] SET_LONG = {
        16'd0, 16'd40, 16'd150, 16'd0, 16'd65535, 16'd65535, 16'd3000, 16'd12, 16'd3
    };

    // DUT signals
    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_we      = 1'b0;
    logic               i_cfg_addr    = REG_DEBOUNCE;
    logic [CFG_W-1:0]   i_cfg_wdata   = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [IN_TDW-1:0]  s_axis_tdata  = '0;  // now_ms[31:0], next_raw, reset_raw, pad
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [OUT_TDW-1:0] m_axis_tdata;        // next_press_event, long_press_event,
                                             // next_level, reset_level, pad

    // Predictor state and register copies
    logic [CFG_W-1:0]  cfg_debounce;
    logic [CFG_W-1:0]  cfg_long;
    logic              btn_last   [2];
    logic              btn_stable [2];
    logic [TIME_W-1:0] btn_chg    [2];
    logic [TIME_W-1:0] hold_start;
    logic              hold_fired;

    // Pending polls and predicted button status
    t_in_beat  poll_q[$];
    t_out_beat status_q[$];

    // Random button activity
    logic [TIME_W-1:0] gen_t;
    logic              gen_lvl [2];
    int unsigned       gen_bnc [2];

    // Driver / monitor bookkeeping
    t_in_beat    tx_poll;
    int unsigned tx_gap       = 0;
    int unsigned tx_mode_left = 0;
    logic        tx_gappy     = 1'b0;
    int unsigned rx_gap       = 0;
    int unsigned rx_mode_left = 0;
    logic        rx_gappy     = 1'b0;
    int unsigned stall_left   = 0;
    logic        stall_start  = 1'b0;
    t_out_beat   rx_got;
    t_out_beat   rx_want;

    int n_queued    = 0;
    int n_beats_out = 0;
    int n_press_ev  = 0;
    int n_long_ev   = 0;
    int n_settings  = 1;
    int mismatches  = 0;

    button_debounce_long_press u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock: 4 time units
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // One debouncer; returns 1 on a stable press edge
    function automatic logic debounce_step(int k, logic raw, logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] since;
        if (raw != btn_last[k]) begin
            btn_last[k] = raw;
            btn_chg[k]  = now;
        end
        since = now - btn_chg[k];
        if (since >= {16'd0, cfg_debounce} && raw != btn_stable[k]) begin
            btn_stable[k] = raw;
            return !raw;
        end
        return 1'b0;
    endfunction

    // Button status that one poll produces
    function automatic t_out_beat predict_poll(t_in_beat p);
        t_out_beat         r;
        logic [TIME_W-1:0] held;
        r = '0;
        r.next_press_event = debounce_step(BTN_NEXT, p.next_raw, p.now_ms);
        if (debounce_step(BTN_RESET, p.reset_raw, p.now_ms)) begin
            hold_start = p.now_ms;
            hold_fired = 1'b0;
        end
        held = p.now_ms - hold_start;
        if (!btn_stable[BTN_RESET] && !hold_fired && held >= {16'd0, cfg_long}) begin
            hold_fired         = 1'b1;
            r.long_press_event = 1'b1;
        end
        r.next_level  = btn_stable[BTN_NEXT];
        r.reset_level = btn_stable[BTN_RESET];
        return r;
    endfunction

    // Gap length: mostly short, a few long
    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 9) < 8) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    task automatic add_poll(logic [TIME_W-1:0] t, logic raw_next, logic raw_reset);
        t_in_beat p;
        p.now_ms    = t;
        p.next_raw  = raw_next;
        p.reset_raw = raw_reset;
        poll_q.push_back(p);
        n_queued++;
    endtask

    // Random presses with bounces, glitches and odd time steps
    task automatic add_random_polls(int n);
        int unsigned db;
        int unsigned lp;
        int unsigned sel;
        logic [1:0]  raw;
        db = cfg_debounce;
        lp = cfg_long;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 35) begin
                gen_t += $urandom_range(0, db + 1);
            end else if (sel < 60) begin
                gen_t += $urandom_range(db, db + 2);
            end else if (sel < 90) begin
                gen_t += $urandom_range(0, lp / 3 + 2);
            end else if (sel < 97) begin
                gen_t += $urandom_range(0, 2);
            end else begin
                gen_t = $urandom();
            end
            for (int k = 0; k < 2; k++) begin
                // second button flips less often so holds get long
                if ($urandom_range(0, (k == BTN_NEXT) ? 7 : 15) == 0) begin
                    gen_lvl[k] = !gen_lvl[k];
                    gen_bnc[k] = $urandom_range(0, 3);
                end
                if (gen_bnc[k] != 0) begin
                    gen_bnc[k]--;
                    raw[k] = 1'($urandom_range(0, 1));
                end else if ($urandom_range(0, 24) == 0) begin
                    raw[k] = !gen_lvl[k];
                end else begin
                    raw[k] = gen_lvl[k];
                end
            end
            add_poll(gen_t, raw[BTN_NEXT], raw[BTN_RESET]);
        end
    endtask

    // Register write, only while no poll is in flight
    task automatic write_cfg(t_cfg_idx idx, logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        case (idx)
            REG_DEBOUNCE:   cfg_debounce = val;
            REG_LONG_PRESS: cfg_long     = val;
            default:        ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Every queued poll has come back, then a short idle wait
    task automatic wait_drained();
        while (n_beats_out != n_queued) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Long receiver hold-off, started by the stimulus
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_left <= 0;
        end else if (stall_start) begin
            stall_left <= LONG_STALL_CYCLES;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end
    end

    // Driver: predict accepted beats, offer the next poll
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                status_q.push_back(predict_poll(t_in_beat'(s_axis_tdata[$bits(t_in_beat)-1:0])));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tx_gap != 0) begin
                    tx_gap        <= tx_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (poll_q.size() != 0) begin
                    tx_poll        = poll_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {{(IN_TDW - $bits(t_in_beat)){1'b0}}, tx_poll};
                    if (tx_mode_left == 0) begin
                        tx_gappy     <= ($urandom_range(0, 2) != 0);
                        tx_mode_left <= $urandom_range(40, 200);
                    end else begin
                        tx_mode_left <= tx_mode_left - 1;
                    end
                    // no gaps while the receiver is held off
                    if (tx_gappy && stall_left == 0 && $urandom_range(0, 2) == 0) begin
                        tx_gap <= pick_gap();
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check result beats, drive back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                rx_got = t_out_beat'(m_axis_tdata[$bits(t_out_beat)-1:0]);
                n_beats_out++;
                n_press_ev += rx_got.next_press_event;
                n_long_ev  += rx_got.long_press_event;
                if (status_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("ERROR: result beat %b with no poll outstanding", rx_got);
                    end
                end else begin
                    rx_want = status_q.pop_front();
                    if (rx_got.next_press_event !== rx_want.next_press_event ||
                        rx_got.long_press_event !== rx_want.long_press_event ||
                        rx_got.next_level       !== rx_want.next_level ||
                        rx_got.reset_level      !== rx_want.reset_level) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("ERROR: result %0d: expected press=%b long=%b lvl=%b/%b",
                                     n_beats_out, rx_want.next_press_event,
                                     rx_want.long_press_event, rx_want.next_level,
                                     rx_want.reset_level);
                            $display("       got      press=%b long=%b lvl=%b/%b",
                                     rx_got.next_press_event, rx_got.long_press_event,
                                     rx_got.next_level, rx_got.reset_level);
                        end
                    end
                end
            end
            if (rx_mode_left == 0) begin
                rx_gappy     <= ($urandom_range(0, 2) != 0);
                rx_mode_left <= $urandom_range(50, 300);
            end else begin
                rx_mode_left <= rx_mode_left - 1;
            end
            if (stall_left != 0) begin
                m_axis_tready <= 1'b0;
            end else if (rx_gap != 0) begin
                rx_gap        <= rx_gap - 1;
                m_axis_tready <= 1'b0;
            end else if (rx_gappy && $urandom_range(0, 3) == 0) begin
                rx_gap        <= pick_gap() - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Stimulus
    initial begin
        cfg_debounce = DEBOUNCE_RST_MS;
        cfg_long     = LONG_PRESS_RST_MS;
        for (int k = 0; k < 2; k++) begin
            btn_last[k]   = 1'b1;
            btn_stable[k] = 1'b1;
            btn_chg[k]    = '0;
            gen_lvl[k]    = 1'b1;
            gen_bnc[k]    = 0;
        end
        hold_start = '0;
        hold_fired = 1'b0;
        gen_t      = '0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset settings: 20 ms debounce, 3000 ms hold
        add_poll(32'd0,    1'b1, 1'b1);
        add_poll(32'd5,    1'b0, 1'b1);   // first button down
        add_poll(32'd24,   1'b0, 1'b1);   // 1 ms short of debounce
        add_poll(32'd25,   1'b0, 1'b1);   // exactly debounce: press event
        add_poll(32'd26,   1'b1, 1'b1);   // bounce restarts timer
        add_poll(32'd30,   1'b0, 1'b1);
        add_poll(32'd70,   1'b1, 1'b1);
        add_poll(32'd90,   1'b1, 1'b1);   // release accepted, no event
        add_poll(32'd100,  1'b1, 1'b0);
        add_poll(32'd120,  1'b1, 1'b0);   // second button stable, hold starts
        add_poll(32'd3119, 1'b1, 1'b0);   // 1 ms short of hold
        add_poll(32'd3120, 1'b1, 1'b0);   // long press
        add_poll(32'd4000, 1'b1, 1'b0);   // fires only once per press
        add_poll(32'd4010, 1'b1, 1'b1);
        add_poll(32'd4030, 1'b1, 1'b1);
        add_poll(32'd4040, 1'b1, 1'b0);
        add_poll(32'd4060, 1'b1, 1'b0);   // new press re-arms
        add_poll(32'd5000, 1'b1, 1'b1);
        add_poll(32'd5020, 1'b1, 1'b1);   // released before hold time
        add_poll(32'hFFFF_FFF0, 1'b0, 1'b1);
        add_poll(32'h0000_0004, 1'b0, 1'b1); // debounce across time wrap
        add_poll(32'h0000_0100, 1'b1, 1'b0);
        add_poll(32'h0000_0050, 1'b1, 1'b0); // time backwards: huge elapsed
        add_poll(32'h0000_0040, 1'b1, 1'b0); // backwards again: long press
        add_poll(32'hFFFF_FFFF, 1'b1, 1'b1);
        wait_drained();

        // Zero debounce and zero hold: everything in the same poll
        write_cfg(REG_DEBOUNCE, 16'd0);
        write_cfg(REG_LONG_PRESS, 16'd0);
        n_settings++;
        add_poll(32'd10, 1'b1, 1'b1);
        add_poll(32'd11, 1'b0, 1'b0);
        add_poll(32'd12, 1'b0, 1'b0);
        add_poll(32'd13, 1'b1, 1'b1);
        gen_t = 32'd13;
        wait_drained();

        // Random activity under each setting
        for (int s = 0; s < N_SETS; s++) begin
            write_cfg(REG_DEBOUNCE, SET_DEBOUNCE[s*CFG_W +: CFG_W]);
            write_cfg(REG_LONG_PRESS, SET_LONG[s*CFG_W +: CFG_W]);
            n_settings++;
            if (s % 2 == 1) begin
                gen_t = 32'hFFFF_FFFF - $urandom_range(0, 2000);
            end
            add_random_polls(POLLS_PER_SET);
            if (s == 2) begin
                // hold the receiver off while polls keep coming
                @(posedge i_clk);
                stall_start <= 1'b1;
                @(posedge i_clk);
                stall_start <= 1'b0;
            end
            wait_drained();
        end

        mismatches += status_q.size();
        $display("Summary: %0d polls checked over %0d register settings, incl. 0 and 65535",
                 n_beats_out, n_settings);
        $display("  %0d press events, %0d long-press events, %0d mismatches",
                 n_press_ev, n_long_ev, mismatches);
        if (mismatches == 0) begin
            $display("PASS button_debounce_long_press");
        end else begin
            $display("FAIL button_debounce_long_press");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #TIMEOUT_UNITS;
        $display("FAIL button_debounce_long_press");
        $finish;
    end

endmodule
